// ===== rtl/twq_pkg.sv =====
// ----------------------------------------------------------------------------
// twq_pkg
// shared types, codes and sizes for the timed wake-up event queue
// ----------------------------------------------------------------------------
package twq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int TIME_BITS     = 32;
  localparam int MAX_WAKE      = 3;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int TREE_N  = 1 << IDX_W;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL_W   = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int POP_W   = (MAX_WAKE > 1) ? $clog2(MAX_WAKE) : 1;

  // fixed field widths of the channels
  localparam int REQ_W   = 2;
  localparam int MASK_W  = 3;
  localparam int LEFT_W  = 5;
  localparam int NUM_REQ = 1 << REQ_W;

  typedef enum logic {
    CMD_SCHEDULE = 1'b0,
    CMD_DISPATCH = 1'b1
  } cmd_code_t;

  typedef enum logic [2:0] {
    STAT_ACCEPTED   = 3'd0,
    STAT_PAST       = 3'd1,
    STAT_FULL       = 3'd2,
    STAT_DISPATCHED = 3'd3,
    STAT_EMPTY      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REDUCE,
    ST_MATCH,
    ST_POP
  } ctrl_state_t;

  typedef struct packed {
    logic                  command;
    logic [TIME_BITS-1:0]  wake_time;
    logic [REQ_W-1:0]      requester;
  } in_t;

  typedef struct packed {
    status_t               status;
    logic [MASK_W-1:0]     wake_mask;
    logic [TIME_BITS-1:0]  now_time;
    logic [LEFT_W-1:0]     entries_left;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic schedule;
    logic finish_empty;
    logic load;
    logic reduce;
    logic match;
    logic pop;
    logic finish_dispatch;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_dispatch;
    logic empty;
    logic pop_last;
  } dp_stat_t;

  // one node of the minimum-time reduction
  typedef struct packed {
    logic                  v;
    logic [TIME_BITS-1:0]  t;
  } node_t;

endpackage

// ===== rtl/timed_wakeup_event_queue.sv =====
// ----------------------------------------------------------------------------
// timed_wakeup_event_queue
// queue of wake entries (time, requester); dispatch pops the earliest ones
// ----------------------------------------------------------------------------
//
//  channel   ports                       beat taken when
//  -------   -------------------------   -------------------------------
//  input     start, busy, in_item        start high and busy low
//  result    out_strobe, out_result      out_strobe high (one cycle)
//
// a schedule beat passes through a decode/write step, then the result
// strobe, during which the next beat may already be taken
// a dispatch beat runs decode, the reduction levels, a match step and the
// pops: the minimum-time search reduces one tree level per cycle, then the
// match step marks the same-time entries and pops up to MAX_WAKE of them
// a dispatch on an empty queue ends after decode, like a schedule
// reset is synchronous, active low; it clears valid bits, fill count and time
// results are never held off, so out_strobe pulses exactly once per beat
//
module timed_wakeup_event_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  twq_pkg::in_t   in_item,
  output logic           out_strobe,
  output twq_pkg::out_t  out_result
);

  // command and status between sequencer and datapath
  twq_pkg::dp_cmd_t   cmd;
  twq_pkg::dp_stat_t  stat;

  // sequencer: decode, reduction levels, match, pop steps
  twq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // entry registers, search tree and result register
  twq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_result (out_result),
    .out_strobe (out_strobe)
  );

endmodule

// ===== rtl/twq_ctrl.sv =====
// ----------------------------------------------------------------------------
// twq_ctrl
// sequencer: decode, min-time reduction levels, match, pop steps
// ----------------------------------------------------------------------------
module twq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  twq_pkg::dp_stat_t  stat,
  output twq_pkg::dp_cmd_t   cmd
);

  twq_pkg::ctrl_state_t            state_r, state_nxt;
  logic [twq_pkg::LVL_W-1:0]       lvl_r, lvl_nxt;
  logic [twq_pkg::POP_W-1:0]       pop_cnt_r, pop_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= twq_pkg::ST_IDLE;
      lvl_r     <= '0;
      pop_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      lvl_r     <= lvl_nxt;
      pop_cnt_r <= pop_cnt_nxt;
    end
  end

  assign busy = (state_r != twq_pkg::ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    lvl_nxt     = lvl_r;
    pop_cnt_nxt = pop_cnt_r;
    cmd         = '0;
    case (state_r)
      twq_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = twq_pkg::ST_DECODE;
        end
      end
      twq_pkg::ST_DECODE: begin
        if (!stat.is_dispatch) begin
          cmd.schedule = 1'b1;
          state_nxt    = twq_pkg::ST_IDLE;
        end else if (stat.empty) begin
          cmd.finish_empty = 1'b1;
          state_nxt        = twq_pkg::ST_IDLE;
        end else begin
          cmd.load  = 1'b1;
          lvl_nxt   = '0;
          state_nxt = twq_pkg::ST_REDUCE;
        end
      end
      twq_pkg::ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (lvl_r == twq_pkg::LVL_W'(twq_pkg::IDX_W - 1)) begin
          state_nxt = twq_pkg::ST_MATCH;
        end else begin
          lvl_nxt = lvl_r + 1'b1;
        end
      end
      twq_pkg::ST_MATCH: begin
        cmd.match   = 1'b1;
        pop_cnt_nxt = '0;
        state_nxt   = twq_pkg::ST_POP;
      end
      twq_pkg::ST_POP: begin
        cmd.pop = 1'b1;
        if (stat.pop_last || pop_cnt_r == twq_pkg::POP_W'(twq_pkg::MAX_WAKE - 1)) begin
          cmd.finish_dispatch = 1'b1;
          state_nxt           = twq_pkg::ST_IDLE;
        end else begin
          pop_cnt_nxt = pop_cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = twq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/twq_datapath.sv =====
// ----------------------------------------------------------------------------
// twq_datapath
// entry registers, min-time reduction, same-time match and pop, result beat
// ----------------------------------------------------------------------------
module twq_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  twq_pkg::in_t       in_item,
  input  twq_pkg::dp_cmd_t   cmd,
  output twq_pkg::dp_stat_t  stat,
  output twq_pkg::out_t      out_result,
  output logic               out_strobe
);

  localparam int D = twq_pkg::QUEUE_DEPTH;

  twq_pkg::in_t                      in_r, in_nxt;
  logic [twq_pkg::TIME_BITS-1:0]     ent_time_r [D];
  logic [twq_pkg::TIME_BITS-1:0]     ent_time_nxt [D];
  logic [twq_pkg::REQ_W-1:0]         ent_req_r [D];
  logic [twq_pkg::REQ_W-1:0]         ent_req_nxt [D];
  logic [D-1:0]                      valid_r, valid_nxt;
  logic [D-1:0]                      hit_r, hit_nxt;
  logic [twq_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [twq_pkg::TIME_BITS-1:0]     cur_time_r, cur_time_nxt;
  logic [twq_pkg::MASK_W-1:0]        mask_r, mask_nxt;
  twq_pkg::node_t                    node_r [twq_pkg::TREE_N];
  twq_pkg::node_t                    node_nxt [twq_pkg::TREE_N];
  twq_pkg::out_t                     out_r, out_nxt;
  logic                              strobe_r, strobe_nxt;

  // schedule helpers
  logic                              any_free;
  logic [twq_pkg::IDX_W-1:0]         free_idx;
  logic                              is_past;
  logic                              is_full;

  // pop helpers
  logic [D-1:0]                      req_vec [twq_pkg::NUM_REQ];
  logic [twq_pkg::REQ_W-1:0]         sel_req;
  logic [D-1:0]                      cand;
  logic [twq_pkg::IDX_W-1:0]         pop_idx;
  logic [D-1:0]                      pop_onehot;

  function automatic logic [twq_pkg::MASK_W-1:0] req_bit(input logic [twq_pkg::REQ_W-1:0] r);
    logic [twq_pkg::MASK_W-1:0] b;
    b = '0;
    if (r != '0) begin
      b = twq_pkg::MASK_W'(1) << (r - 1'b1);
    end
    return b;
  endfunction

  function automatic twq_pkg::node_t pick_min(input twq_pkg::node_t a, input twq_pkg::node_t b);
    twq_pkg::node_t m;
    if (a.v && (!b.v || a.t <= b.t)) begin
      m = a;
    end else begin
      m = b;
    end
    return m;
  endfunction

  // lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        any_free = 1'b1;
        free_idx = twq_pkg::IDX_W'(i);
      end
    end
  end

  assign is_past = (count_r != '0) && (in_r.wake_time < cur_time_r);
  assign is_full = (count_r >= twq_pkg::CNT_W'(D)) || !any_free;

  // lowest requester among same-time hits, then lowest slot
  always_comb begin
    for (int r = 0; r < twq_pkg::NUM_REQ; r++) begin
      for (int i = 0; i < D; i++) begin
        req_vec[r][i] = hit_r[i] && (ent_req_r[i] == twq_pkg::REQ_W'(r));
      end
    end
    sel_req = '0;
    for (int r = twq_pkg::NUM_REQ - 1; r >= 0; r--) begin
      if (req_vec[r] != '0) begin
        sel_req = twq_pkg::REQ_W'(r);
      end
    end
    cand    = req_vec[sel_req];
    pop_idx = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pop_idx = twq_pkg::IDX_W'(i);
      end
    end
    pop_onehot = '0;
    pop_onehot[pop_idx] = 1'b1;
  end

  assign stat.is_dispatch = (in_r.command == twq_pkg::CMD_DISPATCH);
  assign stat.empty       = (count_r == '0);
  assign stat.pop_last    = ((hit_r & ~pop_onehot) == '0);

  always_comb begin
    in_nxt       = in_r;
    ent_time_nxt = ent_time_r;
    ent_req_nxt  = ent_req_r;
    valid_nxt    = valid_r;
    hit_nxt      = hit_r;
    count_nxt    = count_r;
    cur_time_nxt = cur_time_r;
    mask_nxt     = mask_r;
    node_nxt     = node_r;
    out_nxt      = out_r;
    strobe_nxt   = 1'b0;

    if (cmd.capture) begin
      in_nxt = in_item;
    end

    if (cmd.schedule) begin
      if (is_past) begin
        out_nxt.status = twq_pkg::STAT_PAST;
      end else if (is_full) begin
        out_nxt.status = twq_pkg::STAT_FULL;
      end else begin
        ent_time_nxt[free_idx] = in_r.wake_time;
        ent_req_nxt[free_idx]  = in_r.requester;
        valid_nxt[free_idx]    = 1'b1;
        count_nxt              = count_r + 1'b1;
        out_nxt.status         = twq_pkg::STAT_ACCEPTED;
      end
      out_nxt.wake_mask    = '0;
      out_nxt.now_time     = cur_time_r;
      out_nxt.entries_left = twq_pkg::LEFT_W'(count_nxt);
      strobe_nxt           = 1'b1;
    end

    if (cmd.finish_empty) begin
      out_nxt.status       = twq_pkg::STAT_EMPTY;
      out_nxt.wake_mask    = '0;
      out_nxt.now_time     = cur_time_r;
      out_nxt.entries_left = twq_pkg::LEFT_W'(count_r);
      strobe_nxt           = 1'b1;
    end

    if (cmd.load) begin
      for (int i = 0; i < twq_pkg::TREE_N; i++) begin
        if (i < D) begin
          node_nxt[i].v = valid_r[i];
          node_nxt[i].t = ent_time_r[i];
        end else begin
          node_nxt[i] = '0;
        end
      end
      mask_nxt = '0;
    end

    // one tree level per step, results packed into the lower half
    if (cmd.reduce) begin
      for (int i = 0; i < twq_pkg::TREE_N / 2; i++) begin
        node_nxt[i] = pick_min(node_r[2*i], node_r[2*i+1]);
      end
    end

    if (cmd.match) begin
      for (int i = 0; i < D; i++) begin
        hit_nxt[i] = valid_r[i] && (ent_time_r[i] == node_r[0].t);
      end
      cur_time_nxt = node_r[0].t;
    end

    if (cmd.pop) begin
      valid_nxt[pop_idx] = 1'b0;
      hit_nxt[pop_idx]   = 1'b0;
      count_nxt          = count_r - 1'b1;
      mask_nxt           = mask_r | req_bit(sel_req);
    end

    if (cmd.finish_dispatch) begin
      out_nxt.status       = twq_pkg::STAT_DISPATCHED;
      out_nxt.wake_mask    = mask_nxt;
      out_nxt.now_time     = cur_time_r;
      out_nxt.entries_left = twq_pkg::LEFT_W'(count_nxt);
      strobe_nxt           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    ent_time_r <= ent_time_nxt;
    ent_req_r  <= ent_req_nxt;
    node_r     <= node_nxt;
    mask_r     <= mask_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      hit_r      <= '0;
      count_r    <= '0;
      cur_time_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      hit_r      <= hit_nxt;
      count_r    <= count_nxt;
      cur_time_r <= cur_time_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  assign out_result = out_r;
  assign out_strobe = strobe_r;

  // fill count tracks the valid bits
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count out of step with valid bits");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= twq_pkg::CNT_W'(D))
    else $error("entry count beyond queue depth");

  a_pop_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (hit_r != '0))
    else $error("pop step with no same-time entry");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("result strobe held longer than one cycle");

endmodule

// ===== dv/twq_checker.sv =====
// ----------------------------------------------------------------------------
// twq_checker
// watches both channels of the wake-up queue, keeps its own copy of the
// entries and the current time, and compares every result beat against it
// ----------------------------------------------------------------------------
module twq_checker
  import twq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  busy,
  input  in_t   in_item,
  input  logic  out_strobe,
  input  out_t  out_result,
  output int    fail_count,
  output int    results_waiting,
  output int    results_checked
);

  // shadow queue contents
  logic [TIME_BITS-1:0] slot_time [QUEUE_DEPTH];
  logic [REQ_W-1:0]     slot_req  [QUEUE_DEPTH];
  logic                 slot_used [QUEUE_DEPTH];
  int                   fill;
  logic [TIME_BITS-1:0] now_t;

  out_t wakeups_due[$];
  out_t due;
  int   n_fail;
  int   n_checked;

  // earliest live slot by time, then by lower requester; -1 when empty
  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (slot_used[i] && (best < 0 || slot_time[i] < slot_time[best] ||
          (slot_time[i] == slot_time[best] && slot_req[i] < slot_req[best])))
        best = i;
    end
    return best;
  endfunction

  function automatic out_t predict_wakeup(in_t item);
    out_t                 res;
    int                   idx;
    int                   popped;
    logic [TIME_BITS-1:0] pop_t;
    res = '0;
    idx = -1;
    if (item.command == CMD_SCHEDULE) begin
      // past check wins over full check
      if (fill != 0 && item.wake_time < now_t) begin
        res.status = STAT_PAST;
      end else if (fill >= QUEUE_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (!slot_used[i] && idx < 0) idx = i;
        slot_time[idx] = item.wake_time;
        slot_req[idx]  = item.requester;
        slot_used[idx] = 1'b1;
        fill++;
        res.status = STAT_ACCEPTED;
      end
    end else begin
      idx = earliest_slot();
      if (idx < 0) begin
        res.status = STAT_EMPTY;
      end else begin
        pop_t  = slot_time[idx];
        popped = 0;
        while (idx >= 0 && popped < MAX_WAKE && slot_time[idx] == pop_t) begin
          slot_used[idx] = 1'b0;
          fill--;
          // requester zero wakes nobody
          if (slot_req[idx] != '0) res.wake_mask[slot_req[idx] - 1] = 1'b1;
          popped++;
          idx = earliest_slot();
        end
        now_t      = pop_t;
        res.status = STAT_DISPATCHED;
      end
    end
    res.now_time     = now_t;
    res.entries_left = LEFT_W'(fill);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) slot_used[i] = 1'b0;
      fill      = 0;
      now_t     = '0;
      n_fail    = 0;
      n_checked = 0;
      wakeups_due.delete();
    end else begin
      if (out_strobe) begin
        if (wakeups_due.size() == 0) begin
          $error("result beat with nothing pending");
          n_fail++;
        end else begin
          due = wakeups_due.pop_front();
          n_checked++;
          if (out_result.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_result.status);
            n_fail++;
          end
          if (out_result.wake_mask !== due.wake_mask) begin
            $error("wake_mask: expected %b, got %b", due.wake_mask,
                   out_result.wake_mask);
            n_fail++;
          end
          if (out_result.now_time !== due.now_time) begin
            $error("now_time: expected %0h, got %0h", due.now_time,
                   out_result.now_time);
            n_fail++;
          end
          if (out_result.entries_left !== due.entries_left) begin
            $error("entries_left: expected %0d, got %0d", due.entries_left,
                   out_result.entries_left);
            n_fail++;
          end
        end
      end
      if (start && !busy) wakeups_due.push_back(predict_wakeup(in_item));
    end
    fail_count      <= n_fail;
    results_waiting <= wakeups_due.size();
    results_checked <= n_checked;
  end

endmodule

// ===== dv/tb_timed_wakeup_event_queue.sv =====
// ----------------------------------------------------------------------------
// tb_timed_wakeup_event_queue
// drives schedule and dispatch beats into the wake-up queue: a directed
// opening for the corner cases, then random traffic in fill and drain phases;
// a side checker predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb_timed_wakeup_event_queue;
  import twq_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_strobe;
  out_t out_result;

  int fail_count;
  int results_waiting;
  int results_checked;

  // beats sent, by kind
  int n_sched;
  int n_disp;

  // 10 time unit clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  timed_wakeup_event_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

  twq_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_strobe      (out_strobe),
    .out_result      (out_result),
    .fail_count      (fail_count),
    .results_waiting (results_waiting),
    .results_checked (results_checked)
  );

  // hard stop far beyond the slowest legal run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the beat
  // was taken, so the caller may drive the next beat right away
  task automatic send_wakeup(input cmd_code_t cmd, input logic [TIME_BITS-1:0] t,
                             input logic [REQ_W-1:0] req);
    in_t item;
    item.command   = cmd;
    item.wake_time = t;
    item.requester = req;
    start   <= 1'b1;
    in_item <= item;
    // busy seen at the edge itself, before the block updates it
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (cmd == CMD_SCHEDULE) n_sched++;
    else n_disp++;
  endtask

  // start low with junk on the payload
  task automatic idle_burst(input int cycles);
    in_t junk;
    junk.command   = 1'($urandom);
    junk.wake_time = $urandom;
    junk.requester = REQ_W'($urandom);
    start   <= 1'b0;
    in_item <= junk;
    repeat (cycles) @(negedge clk);
  endtask

  initial begin
    int                   disp_pct;
    int                   pick;
    int                   waited;
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] t_base;
    logic [REQ_W-1:0]     req;

    n_sched  = 0;
    n_disp   = 0;
    disp_pct = 50;
    start    = 1'b0;
    in_item  = '0;
    rst_n    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed opening ----
    // dispatch with nothing queued
    send_wakeup(CMD_DISPATCH, '1, 2'd3);
    // latest possible time, then dispatch it: now sits at the top
    send_wakeup(CMD_SCHEDULE, '1, 2'd3);
    send_wakeup(CMD_DISPATCH, '0, 2'd0);
    // empty queue takes a time far below now
    send_wakeup(CMD_SCHEDULE, 32'd7, 2'd2);
    // pop it so now drops back to 7 with the queue empty again
    send_wakeup(CMD_DISPATCH, '0, 2'd0);
    // same-time group of four, requester zero among them
    send_wakeup(CMD_SCHEDULE, 32'd7, 2'd2);
    send_wakeup(CMD_SCHEDULE, 32'd7, 2'd0);
    send_wakeup(CMD_SCHEDULE, 32'd7, 2'd1);
    send_wakeup(CMD_SCHEDULE, 32'd7, 2'd3);
    // below now on a non-empty queue
    send_wakeup(CMD_SCHEDULE, 32'd6, 2'd1);
    // fill up to the depth
    for (int i = 0; i < QUEUE_DEPTH - 4; i++)
      send_wakeup(CMD_SCHEDULE, 32'd9, REQ_W'($urandom_range(1, 3)));
    // full, then past on a full queue (past check comes first)
    send_wakeup(CMD_SCHEDULE, 32'd9, 2'd1);
    send_wakeup(CMD_SCHEDULE, '0, 2'd1);
    // three of the four ties go in one dispatch, the fourth in the next
    send_wakeup(CMD_DISPATCH, 32'h5a5a_a5a5, 2'd2);
    send_wakeup(CMD_DISPATCH, 32'ha5a5_5a5a, 2'd1);

    // ---- random traffic ----
    // times cluster just above a slowly moving base so ties and multi-pops
    // are common; a few land below it or anywhere in the full range
    t_base = 32'd9;
    for (int i = 0; i < 450; i++) begin
      // phases that lean toward filling, mixing or draining
      if (i % 30 == 0) begin
        case ($urandom_range(0, 2))
          0:       disp_pct = 15;
          1:       disp_pct = 45;
          default: disp_pct = 70;
        endcase
      end
      // gaps on the input side, none in the closing stretch
      if (i < 370 && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 11));
      if ($urandom_range(0, 99) < disp_pct) begin
        send_wakeup(CMD_DISPATCH, $urandom, REQ_W'($urandom));
        t_base += $urandom_range(0, 2);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 3) t = $urandom;
        else if (pick < 10) t = t_base - $urandom_range(1, 8);
        else t = t_base + $urandom_range(0, 5);
        req = ($urandom_range(0, 9) == 0) ? 2'd0 : REQ_W'($urandom_range(1, 3));
        send_wakeup(CMD_SCHEDULE, t, req);
      end
    end
    start <= 1'b0;

    // drain: every beat owes one result, then wait out any strays
    waited = 0;
    while (results_waiting != 0 && waited < 1000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);

    $display("covered %0d schedule and %0d dispatch beats, %0d results compared",
             n_sched, n_disp, results_checked);
    $display("including empty, past-time, full and same-time multi-wake cases");
    if (fail_count == 0 && results_waiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
